// ===== hdl/received_frame_checker_macros.svh =====
// ---------------------------------------------------------------------------
// Received frame checker assertion macros
// Concurrent assertion forms used by the checker's datapath module.
// ---------------------------------------------------------------------------
`ifndef RECEIVED_FRAME_CHECKER_MACROS_SVH
`define RECEIVED_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("received_frame_checker: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("received_frame_checker: assertion failed");

`endif

// ===== hdl/rfc_pkg.sv =====
// ---------------------------------------------------------------------------
// Received frame checker package
// Types, constants and the byte-wise CRC update shared by the checker.
// ---------------------------------------------------------------------------
package rfc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_VERSION  = 2'd0,
    REG_ADDRESS  = 2'd1,
    REG_ACK_MASK = 2'd2
  } rfc_reg_e;

  typedef enum logic [1:0] {
    VERDICT_DROP        = 2'd0,
    VERDICT_NACK        = 2'd1,
    VERDICT_DELIVER     = 2'd2,
    VERDICT_DELIVER_ACK = 2'd3
  } rfc_verdict_e;

  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // Byte positions within a frame.
  localparam logic [7:0] HeaderIdx   = 8'd0;
  localparam logic [7:0] TypeIdx     = 8'd1;
  localparam logic [7:0] AddressIdx  = 8'd2;
  localparam logic [7:0] CrcStartIdx = 8'd2;
  localparam logic [7:0] PayloadIdx  = 8'd5;
  localparam logic [7:0] MinLastIdx  = 8'd4;
  localparam logic [7:0] CountMax    = 8'd255;

  localparam logic [4:0] VersionReset = 5'd1;
  localparam logic [7:0] AddressReset = 8'd0;
  localparam logic [2:0] AckMaskReset = 3'd1;

  typedef struct packed {
    logic [4:0] version;
    logic [7:0] address;
    logic [2:0] ack_mask;
  } rfc_cfg_t;

  typedef struct packed {
    logic         payload_valid;
    logic [7:0]   payload_byte;
    logic         frame_done;
    rfc_verdict_e verdict;
    logic [7:0]   frame_type;
    logic [2:0]   ack_bits;
    logic [7:0]   payload_length;
  } rfc_result_t;

  // Reflected CRC-CCITT (polynomial 0x8408) advanced by one byte.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    logic [7:0] e;
    d = b ^ crc[7:0];
    e = d ^ {d[3:0], 4'b0000};
    crc_feed = {e, crc[15:8]} ^ {12'h000, e[7:4]} ^ {5'b00000, e, 3'b000};
  endfunction

endpackage

// ===== hdl/rfc_if.sv =====
// ---------------------------------------------------------------------------
// Received frame checker stream interfaces
// Valid/ready channels for incoming frame bytes and per-byte results.
// ---------------------------------------------------------------------------
interface rfc_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface rfc_rsp_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       frame_done;
  logic [1:0] verdict;
  logic [7:0] frame_type;
  logic [2:0] ack_bits;
  logic [7:0] payload_length;

  modport source (
    output valid, output payload_valid, output payload_byte, output frame_done,
    output verdict, output frame_type, output ack_bits, output payload_length,
    input  ready
  );
  modport sink (
    input  valid, input payload_valid, input payload_byte, input frame_done,
    input  verdict, input frame_type, input ack_bits, input payload_length,
    output ready
  );
endinterface

// ===== hdl/received_frame_checker.sv =====
// ---------------------------------------------------------------------------
// Received frame checker
// Checks a received radio frame byte by byte: header, address, length and
// reflected CRC-CCITT, with payload bytes passed on two bytes late.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake              Carries
// req_i     in         valid/ready            data_byte, is_last
// rsp_o     out        valid/ready            payload and frame verdict
// apb       in/out     psel/penable, pready   three configuration registers
//
// Each request yields exactly one result, from the input register to the
// result register; a new request can be taken every cycle unless rsp_o
// stalls. The byte-wise CRC step and the verdict compare sit between them.
// A stalled result holds the result register; the input register still
// takes one more request, and further requests wait until rsp_o drains.
// Reset is asynchronous and active low and leaves the block ready for a
// new frame at once, with no clearing pass.
// ---------------------------------------------------------------------------
module received_frame_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rfc_pkg::ApbDataW-1:0]  pwdata,
  output logic [rfc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  rfc_req_if.sink                       req_i,
  rfc_rsp_if.source                     rsp_o
);

  rfc_pkg::rfc_cfg_t cfg;

  rfc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rfc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req    (req_i),
    .rsp    (rsp_o)
  );

endmodule

// ===== hdl/rfc_apb_regs.sv =====
// ---------------------------------------------------------------------------
// Received frame checker configuration registers
// APB-style register file holding version, node address and ack mask.
// ---------------------------------------------------------------------------
module rfc_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rfc_pkg::ApbDataW-1:0]  pwdata,
  output logic [rfc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output rfc_pkg::rfc_cfg_t             cfg_o
);

  logic [1:0]        reg_idx;
  logic              wr_en;
  rfc_pkg::rfc_cfg_t cfg_q;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.version  <= rfc_pkg::VersionReset;
      cfg_q.address  <= rfc_pkg::AddressReset;
      cfg_q.ack_mask <= rfc_pkg::AckMaskReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        rfc_pkg::REG_VERSION:  cfg_q.version  <= pwdata[4:0];
        rfc_pkg::REG_ADDRESS:  cfg_q.address  <= pwdata[7:0];
        rfc_pkg::REG_ACK_MASK: cfg_q.ack_mask <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rfc_pkg::REG_VERSION:  prdata = {27'd0, cfg_q.version};
      rfc_pkg::REG_ADDRESS:  prdata = {24'd0, cfg_q.address};
      rfc_pkg::REG_ACK_MASK: prdata = {29'd0, cfg_q.ack_mask};
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== hdl/rfc_core.sv =====
// ---------------------------------------------------------------------------
// Received frame checker datapath
// Input register, frame state with CRC, and the result register.
// ---------------------------------------------------------------------------
`include "received_frame_checker_macros.svh"

module rfc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfc_pkg::rfc_cfg_t cfg_i,
  rfc_req_if.sink           req,
  rfc_rsp_if.source         rsp
);

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 in_last_q;
  logic                 adv;

  logic                 out_valid_q;
  rfc_pkg::rfc_result_t out_q;
  rfc_pkg::rfc_result_t res_d;

  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  dly0_q, dly0_d;
  logic [7:0]  dly1_q, dly1_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  addr_q, addr_d;

  logic [7:0]  hdr_eff;
  logic [7:0]  type_eff;
  logic [7:0]  addr_eff;
  logic [15:0] crc_fed;
  logic [15:0] rx_crc;
  logic        len_ok;
  logic        hdr_ok;

  // The item in the input register moves on whenever the result register
  // is empty or being emptied in this cycle.
  assign adv       = in_valid_q && (!out_valid_q || rsp.ready);
  assign req.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req.ready) begin
      in_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      in_byte_q <= req.data_byte;
      in_last_q <= req.is_last;
    end
  end

  always_comb begin
    hdr_eff  = (cnt_q == rfc_pkg::HeaderIdx)  ? in_byte_q : hdr_q;
    type_eff = (cnt_q == rfc_pkg::TypeIdx)    ? in_byte_q : type_q;
    addr_eff = (cnt_q == rfc_pkg::AddressIdx) ? in_byte_q : addr_q;
    crc_fed  = (cnt_q >= rfc_pkg::CrcStartIdx) ? rfc_pkg::crc_feed(crc_q, dly1_q) : crc_q;
    rx_crc   = {dly0_q, in_byte_q};
    len_ok   = (cnt_q >= rfc_pkg::MinLastIdx) && (cnt_q != rfc_pkg::CountMax);
    hdr_ok   = (hdr_eff[7:3] == cfg_i.version) && (addr_eff == cfg_i.address);

    res_d = '0;
    res_d.payload_valid = (cnt_q >= rfc_pkg::PayloadIdx);
    res_d.payload_byte  = res_d.payload_valid ? dly1_q : 8'd0;

    if (in_last_q) begin
      // The last byte closes the frame and all frame state starts afresh.
      cnt_d  = '0;
      crc_d  = '0;
      dly0_d = '0;
      dly1_d = '0;
      hdr_d  = '0;
      type_d = '0;
      addr_d = '0;
      res_d.frame_done     = 1'b1;
      res_d.frame_type     = type_eff;
      res_d.ack_bits       = hdr_eff[2:0];
      res_d.payload_length = len_ok ? (cnt_q - rfc_pkg::MinLastIdx) : 8'd0;
      priority if (!len_ok || !hdr_ok) begin
        res_d.verdict = rfc_pkg::VERDICT_DROP;
      end else if (crc_fed != rx_crc) begin
        res_d.verdict = rfc_pkg::VERDICT_NACK;
      end else if ((hdr_eff[2:0] & cfg_i.ack_mask) != 3'd0) begin
        res_d.verdict = rfc_pkg::VERDICT_DELIVER_ACK;
      end else begin
        res_d.verdict = rfc_pkg::VERDICT_DELIVER;
      end
    end else begin
      cnt_d  = (cnt_q != rfc_pkg::CountMax) ? cnt_q + 8'd1 : cnt_q;
      crc_d  = crc_fed;
      dly0_d = in_byte_q;
      dly1_d = dly0_q;
      hdr_d  = hdr_eff;
      type_d = type_eff;
      addr_d = addr_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      crc_q  <= '0;
      dly0_q <= '0;
      dly1_q <= '0;
      hdr_q  <= '0;
      type_q <= '0;
      addr_q <= '0;
    end else if (adv) begin
      cnt_q  <= cnt_d;
      crc_q  <= crc_d;
      dly0_q <= dly0_d;
      dly1_q <= dly1_d;
      hdr_q  <= hdr_d;
      type_q <= type_d;
      addr_q <= addr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.payload_valid  = out_q.payload_valid;
  assign rsp.payload_byte   = out_q.payload_byte;
  assign rsp.frame_done     = out_q.frame_done;
  assign rsp.verdict        = out_q.verdict;
  assign rsp.frame_type     = out_q.frame_type;
  assign rsp.ack_bits       = out_q.ack_bits;
  assign rsp.payload_length = out_q.payload_length;

  `RFC_ASSERT_NEXT(a_last_clears_frame, clk_i, rst_ni, adv && in_last_q, cnt_q == 8'd0 && crc_q == 16'd0)
  `RFC_ASSERT_NEXT(a_count_steps, clk_i, rst_ni, adv && !in_last_q && cnt_q != rfc_pkg::CountMax, cnt_q == $past(cnt_q) + 8'd1)
  `RFC_ASSERT_IMPL(a_empty_out_advances, clk_i, rst_ni, in_valid_q && !out_valid_q, adv)
  `RFC_ASSERT_NEXT(a_held_request_kept, clk_i, rst_ni, in_valid_q && !adv, in_valid_q && $stable(in_byte_q) && $stable(in_last_q))

endmodule

// ===== tb/received_frame_checker_test.sv =====
// ---------------------------------------------------------------------------
// Received frame checker testbench
// Sends radio frames byte by byte into the checker, predicts the delayed
// payload stream and the per-frame verdict, and compares every result
// against that prediction under random stalls on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module received_frame_checker_test;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseBytes    = 100;
  localparam int unsigned LongHold      = 80;
  localparam int unsigned SettleCycles  = 4;
  localparam logic [1:0]  RegUnused     = 2'd3;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rfc_pkg::ApbAddrW-1:0] paddr;
  logic [rfc_pkg::ApbDataW-1:0] pwdata;
  logic [rfc_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  rfc_req_if req_if ();
  rfc_rsp_if rsp_if ();

  received_frame_checker i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .rsp_o   (rsp_if)
  );

  // Tracks the frame state of the checker and queues the result each request
  // should produce.
  class frame_scoreboard;
    logic [4:0]           version;
    logic [7:0]           address;
    logic [2:0]           ack_mask;
    logic [7:0]           byte_count;
    logic [15:0]          crc;
    logic [7:0]           recent [2];
    logic [7:0]           header_byte;
    logic [7:0]           type_byte;
    logic [7:0]           addr_byte;
    rfc_pkg::rfc_result_t expected_results [$];
    int                   errors;
    int                   requests;
    int                   frames;
    int                   verdict_tally [4];

    function new();
      version  = rfc_pkg::VersionReset;
      address  = rfc_pkg::AddressReset;
      ack_mask = rfc_pkg::AckMaskReset;
      errors   = 0;
      requests = 0;
      frames   = 0;
      foreach (verdict_tally[i]) verdict_tally[i] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count  = '0;
      crc         = '0;
      recent[0]   = '0;
      recent[1]   = '0;
      header_byte = '0;
      type_byte   = '0;
      addr_byte   = '0;
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] data);
      logic [15:0] t;
      t = {8'h00, data ^ c[7:0]};
      t = (t ^ (t << 4)) & 16'h00ff;
      return ((t << 8) | (c >> 8)) ^ (t >> 4) ^ (t << 3);
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        rfc_pkg::REG_VERSION:  version  = value[4:0];
        rfc_pkg::REG_ADDRESS:  address  = value[7:0];
        rfc_pkg::REG_ACK_MASK: ack_mask = value[2:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] register_value(logic [1:0] idx);
      case (idx)
        rfc_pkg::REG_VERSION:  return {27'd0, version};
        rfc_pkg::REG_ADDRESS:  return {24'd0, address};
        rfc_pkg::REG_ACK_MASK: return {29'd0, ack_mask};
        default:               return '0;
      endcase
    endfunction

    function void note_request(logic [7:0] data, logic last);
      rfc_pkg::rfc_result_t r;
      logic [7:0]           n;
      logic [15:0]          rx_crc;
      logic                 len_ok;
      logic [2:0]           ackb;
      r = '0;
      n = byte_count;
      requests++;
      if (n == rfc_pkg::HeaderIdx) header_byte = data;
      else if (n == rfc_pkg::TypeIdx) type_byte = data;
      else if (n == rfc_pkg::AddressIdx) addr_byte = data;
      // The byte leaving the two-deep delay line feeds the CRC and, past the
      // header, goes out as payload.
      if (n >= rfc_pkg::CrcStartIdx) begin
        crc = crc_step(crc, recent[1]);
        if (n >= rfc_pkg::PayloadIdx) begin
          r.payload_valid = 1'b1;
          r.payload_byte  = recent[1];
        end
      end
      if (last) begin
        rx_crc = {recent[0], data};
        len_ok = (n >= rfc_pkg::MinLastIdx) && (n != rfc_pkg::CountMax);
        ackb   = header_byte[2:0];
        if (!len_ok || header_byte[7:3] != version || addr_byte != address) begin
          r.verdict = rfc_pkg::VERDICT_DROP;
        end else if (crc != rx_crc) begin
          r.verdict = rfc_pkg::VERDICT_NACK;
        end else if ((ackb & ack_mask) != 3'd0) begin
          r.verdict = rfc_pkg::VERDICT_DELIVER_ACK;
        end else begin
          r.verdict = rfc_pkg::VERDICT_DELIVER;
        end
        r.frame_done     = 1'b1;
        r.frame_type     = type_byte;
        r.ack_bits       = ackb;
        r.payload_length = len_ok ? n - 8'd4 : 8'd0;
        clear_frame();
      end else begin
        recent[1] = recent[0];
        recent[0] = data;
        if (byte_count != rfc_pkg::CountMax) byte_count++;
      end
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      errors++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) begin
        report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
    endtask

    task check_result(rfc_pkg::rfc_result_t got);
      rfc_pkg::rfc_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
        return;
      end
      want = expected_results.pop_front();
      compare_field("payload_valid", got.payload_valid, want.payload_valid);
      compare_field("payload_byte", got.payload_byte, want.payload_byte);
      compare_field("frame_done", got.frame_done, want.frame_done);
      compare_field("verdict", got.verdict, want.verdict);
      compare_field("frame_type", got.frame_type, want.frame_type);
      compare_field("ack_bits", got.ack_bits, want.ack_bits);
      compare_field("payload_length", got.payload_length, want.payload_length);
      if (want.frame_done) begin
        frames++;
        verdict_tally[want.verdict]++;
      end
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  frame_scoreboard sb;
  logic [7:0]      frame_bytes [$];
  int              send_idle_pct;
  int              recv_idle_pct;
  int              hold_left;
  int              idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Response side: random stalls, plus a long hold-off when one is requested.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    rfc_pkg::rfc_result_t seen;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      seen.payload_valid  = rsp_if.payload_valid;
      seen.payload_byte   = rsp_if.payload_byte;
      seen.frame_done     = rsp_if.frame_done;
      seen.verdict        = rfc_pkg::rfc_verdict_e'(rsp_if.verdict);
      seen.frame_type     = rsp_if.frame_type;
      seen.ack_bits       = rsp_if.ack_bits;
      seen.payload_length = rsp_if.payload_length;
      sb.check_result(seen);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout: no request or result moved for %0d cycles", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a following request can go out without a gap.
  task send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.data_byte <= data;
    req_if.is_last   <= last;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(data, last);
    @(negedge clk_i);
  endtask

  task start_frame(input logic [4:0] ver, input logic [2:0] ackb,
                   input logic [7:0] ftype, input logic [7:0] addr);
    frame_bytes.delete();
    frame_bytes.push_back({ver, ackb});
    frame_bytes.push_back(ftype);
    frame_bytes.push_back(addr);
  endtask

  task add_payload(input int count);
    repeat (count) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task send_frame(input bit append_crc, input bit corrupt_crc);
    logic [15:0] c;
    if (append_crc) begin
      c = '0;
      foreach (frame_bytes[i]) c = sb.crc_step(c, frame_bytes[i]);
      if (corrupt_crc) c = c ^ 16'($urandom_range(1, 16'hffff));
      frame_bytes.push_back(c[15:8]);
      frame_bytes.push_back(c[7:0]);
    end
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Mostly well-formed frames addressed to this node, with a share of wrong
  // versions, foreign addresses, bad CRCs, short frames and plain noise.
  task random_frame();
    int          kind;
    logic [4:0]  ver;
    logic [7:0]  addr;
    int          plen;
    kind = $urandom_range(0, 99);
    ver  = (kind < 8) ? 5'($urandom_range(0, 31)) : sb.version;
    addr = (kind >= 8 && kind < 16) ? 8'($urandom_range(0, 255)) : sb.address;
    plen = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 120) : $urandom_range(0, 12);
    if (kind >= 31 && kind < 37) begin
      frame_bytes.delete();
      add_payload($urandom_range(1, 4));
      send_frame(1'b0, 1'b0);
    end else if (kind >= 37 && kind < 41) begin
      frame_bytes.delete();
      add_payload($urandom_range(1, 12));
      send_frame(1'b0, 1'b0);
    end else begin
      start_frame(ver, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), addr);
      add_payload(plen);
      send_frame(1'b1, kind >= 16 && kind < 31);
    end
  endtask

  // Sender waits for every outstanding result, then for the pipeline to settle.
  task drain();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write followed directly by a read of the same register.
  task apb_write_check(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_register(idx, value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx != RegUnused && prdata != sb.register_value(idx)) begin
      sb.report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                   idx, prdata, sb.register_value(idx)));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task configure(input logic [4:0] ver, input logic [7:0] addr, input logic [2:0] mask);
    drain();
    apb_write_check(rfc_pkg::REG_VERSION, {27'd0, ver});
    apb_write_check(rfc_pkg::REG_ADDRESS, {24'd0, addr});
    apb_write_check(rfc_pkg::REG_ACK_MASK, {29'd0, mask});
    // An index past the register file must leave everything unchanged.
    apb_write_check(RegUnused, $urandom());
    @(negedge clk_i);
  endtask

  initial begin
    int start_count;
    sb               = new();
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_if.valid     = 1'b0;
    req_if.data_byte = '0;
    req_if.is_last   = 1'b0;
    send_idle_pct    = 35;
    recv_idle_pct    = 55;
    hold_left        = 0;
    idle_cycles      = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames under the reset register values.
    start_frame(rfc_pkg::VersionReset, 3'b001, 8'hff, rfc_pkg::AddressReset);
    send_frame(1'b1, 1'b0);
    frame_bytes.delete();
    frame_bytes.push_back(8'hff);
    send_frame(1'b0, 1'b0);
    start_frame(rfc_pkg::VersionReset, 3'b000, 8'h00, rfc_pkg::AddressReset);
    frame_bytes.push_back(8'h00);
    send_frame(1'b0, 1'b0);
    start_frame(rfc_pkg::VersionReset, 3'b110, 8'h00, rfc_pkg::AddressReset);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hff);
    send_frame(1'b1, 1'b1);
    // Wrong version together with a bad CRC must still be dropped.
    start_frame(5'd31, 3'b111, 8'ha5, rfc_pkg::AddressReset);
    send_frame(1'b1, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          configure(5'd31, 8'hff, 3'd7);
          send_idle_pct = 35;
          recv_idle_pct = 55;
        end
        1: begin
          configure(5'd0, 8'h00, 3'd0);
          send_idle_pct = 55;
          recv_idle_pct = 35;
        end
        default: begin
          configure(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                    3'($urandom_range(1, 7)));
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 2) begin
        // The receiver holds off while requests keep coming, so the block
        // fills up and stops taking input.
        hold_left = LongHold;
      end
      start_count = sb.requests;
      while (sb.requests - start_count < PhaseBytes) begin
        random_frame();
        if (phase == 2 && sb.requests - start_count >= PhaseBytes / 2 && hold_left == 0
            && sb.pending() != 0 && $urandom_range(0, 3) == 0) begin
          drain();
        end
      end
      if (phase == 2) begin
        // Longest frame that still has a valid length.
        start_frame(sb.version, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    sb.address);
        add_payload(250);
        send_frame(1'b1, 1'b0);
      end
      if (phase == 3) begin
        // Overlong frame: the byte count saturates and the frame is dropped.
        start_frame(sb.version, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    sb.address);
        add_payload(300);
        send_frame(1'b1, 1'b0);
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d bytes in %0d frames over five register settings and three stall mixes.",
             sb.requests, sb.frames);
    $display("Verdicts: %0d dropped, %0d nacked, %0d delivered, %0d delivered with ack.",
             sb.verdict_tally[rfc_pkg::VERDICT_DROP], sb.verdict_tally[rfc_pkg::VERDICT_NACK],
             sb.verdict_tally[rfc_pkg::VERDICT_DELIVER],
             sb.verdict_tally[rfc_pkg::VERDICT_DELIVER_ACK]);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rfc_pkg.sv
hdl/rfc_if.sv
hdl/rfc_apb_regs.sv
hdl/rfc_core.sv
hdl/received_frame_checker.sv
tb/received_frame_checker_test.sv
